FILE: design/next_fit_bitmap_id_allocator_unit_defines.svh
// assertion macros shared by the id allocator rtl
// expects clk and rst_n in the scope of each use
`ifndef NEXT_FIT_BITMAP_ID_ALLOCATOR_UNIT_DEFINES_SVH
`define NEXT_FIT_BITMAP_ID_ALLOCATOR_UNIT_DEFINES_SVH

// at most one bit of a vector is set on every clock
`define NFBA_CHECK_ONEHOT0(name, vec) \
    name: assert property (@(posedge clk) disable iff (!rst_n) $onehot0(vec)) \
        else $error("more than one bit set where at most one is allowed");

// a condition forces a consequence in the same cycle
`define NFBA_CHECK_IMPL(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

`endif

FILE: design/nfba_pkg.sv
// shared types and constants of the next-fit id allocator
// no dependencies
package nfba_pkg;

    // ids held by one map cell
    localparam int CELL_W = 32;
    localparam int OFF_W  = 5;

    // request codes
    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    // status codes
    localparam logic [1:0] STAT_DONE    = 2'd0;
    localparam logic [1:0] STAT_FULL    = 2'd1;
    localparam logic [1:0] STAT_RANGE   = 2'd2;
    localparam logic [1:0] STAT_NOTUSED = 2'd3;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic             start;
        logic             kill;
        logic             free;
        logic [OFF_W-1:0] off;
    } nfba_cmd_t;

    // search token handed from cell to cell
    typedef struct packed {
        logic valid;
        logic first;
    } nfba_tok_t;

    // report from one cell to the controller
    typedef struct packed {
        logic             tok;
        logic             hit;
        logic             used;
        logic [OFF_W-1:0] slot;
    } nfba_rep_t;

endpackage

FILE: design/next_fit_bitmap_id_allocator_unit.sv
// top level of the next-fit id allocator: controller and chain of map cells
// depends on nfba_pkg, nfba_cell and the assertion macro header
//
// Usage: one request channel (in_valid/in_ready, func, free_id) and one
// result channel (out_valid/out_ready, result_id, status). Every request
// gives exactly one result, in order.
// An allocate transfer loads a search token into the cell that holds the
// next-fit pointer; the token moves one cell of 32 ids per cycle around the
// ring and stops at the first free id. With N = ceil(MAX_IDS/32) cells the
// token goes at most once around the whole ring of N cells before a full
// status is given. A free goes straight from idle to the done state.
// Requests are handled one at a time: in_ready is high while no request is
// in flight, also when a finished result still waits in the output
// register. If the receiver stalls, a second finished result is held
// inside until the output register is taken, and no new request is taken.
// Reset clears the whole used map and the pointer at once; the block takes
// requests in the first cycle after reset.
`include "next_fit_bitmap_id_allocator_unit_defines.svh"

module next_fit_bitmap_id_allocator_unit #(
    parameter int MAX_IDS = 256
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       func,
    input  logic [8:0] free_id,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] result_id,
    output logic [1:0] status
);

    localparam int NCELLS = (MAX_IDS + nfba_pkg::CELL_W - 1) / nfba_pkg::CELL_W;
    localparam int CIW    = (NCELLS > 1) ? $clog2(NCELLS) : 1;
    localparam int GW     = CIW + nfba_pkg::OFF_W;
    localparam int SW     = $clog2(NCELLS + 1) + 1;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_DONE   = 2'd2;

    logic [1:0]    state_reg, state_next;
    logic [SW-1:0] step_reg, step_next;
    logic [GW-1:0] ptr_reg, ptr_next;
    logic [7:0]    res_id_reg, res_id_next;
    logic [1:0]    res_st_reg, res_st_next;
    logic          out_valid_reg, out_valid_next;
    logic [7:0]    result_id_reg, result_id_next;
    logic [1:0]    status_reg, status_next;

    nfba_pkg::nfba_cmd_t cmd;
    nfba_pkg::nfba_tok_t tok_link [NCELLS];
    nfba_pkg::nfba_rep_t rep      [NCELLS];
    logic [NCELLS-1:0]   sel_vec;
    logic [NCELLS-1:0]   hit_vec;
    logic [NCELLS-1:0]   tok_vec;

    logic              in_fire;
    logic              in_range;
    logic [CIW+3:0]    fcell_w;
    logic [CIW-1:0]    fcell;
    logic [CIW-1:0]    ptr_cell;
    logic              any_hit;
    logic              any_used;
    logic [GW-1:0]     hit_id;
    logic [GW:0]       nxt_id;
    logic [GW+7:0]     hit_id_x;

    assign in_ready = (state_reg == ST_IDLE);
    assign in_fire  = in_valid && in_ready;

    // free id decode
    assign in_range = ({4'b0, free_id} < 13'(MAX_IDS));
    assign fcell_w  = {{CIW{1'b0}}, free_id[8:5]};
    assign fcell    = fcell_w[CIW-1:0];
    assign ptr_cell = ptr_reg[GW-1:nfba_pkg::OFF_W];

    // broadcast command
    always_comb
    begin
        cmd.start = in_fire && (func == nfba_pkg::FUNC_ALLOC);
        cmd.free  = in_fire && (func == nfba_pkg::FUNC_FREE) && in_range;
        cmd.kill  = (state_reg == ST_SEARCH) && !any_hit && (step_reg == SW'(NCELLS));
        cmd.off   = (state_reg == ST_IDLE) ? free_id[4:0]
                                           : ptr_reg[nfba_pkg::OFF_W-1:0];
    end

    // ring of map cells
    for (genvar i = 0; i < NCELLS; i++)
    begin : g_cell
        localparam int VB = (MAX_IDS - i * nfba_pkg::CELL_W >= nfba_pkg::CELL_W)
                          ? nfba_pkg::CELL_W : MAX_IDS - i * nfba_pkg::CELL_W;

        assign sel_vec[i] = (((state_reg == ST_IDLE) && (func == nfba_pkg::FUNC_FREE))
                             ? fcell : ptr_cell) == CIW'(i);
        assign hit_vec[i] = rep[i].hit;
        assign tok_vec[i] = rep[i].tok;

        nfba_cell #(
            .VALID_BITS (VB)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .cmd     (cmd),
            .sel     (sel_vec[i]),
            .tok_in  (tok_link[(i + NCELLS - 1) % NCELLS]),
            .tok_out (tok_link[i]),
            .rep     (rep[i])
        );
    end

    // gather cell reports
    always_comb
    begin
        any_hit  = 1'b0;
        any_used = 1'b0;
        hit_id   = '0;
        for (int i = 0; i < NCELLS; i++)
        begin
            any_hit  = any_hit | rep[i].hit;
            any_used = any_used | (sel_vec[i] & rep[i].used);
            if (rep[i].hit)
            begin
                hit_id = hit_id | {CIW'(i), rep[i].slot};
            end
        end
    end

    // id after the hit; the controller wraps it at the pool size
    assign nxt_id   = {1'b0, hit_id} + (GW + 1)'(1);
    assign hit_id_x = {8'b0, hit_id};

    // controller
    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        ptr_next       = ptr_reg;
        res_id_next    = res_id_reg;
        res_st_next    = res_st_reg;
        out_valid_next = out_valid_reg;
        result_id_next = result_id_reg;
        status_next    = status_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    res_id_next = '0;
                    step_next   = '0;
                    if (func == nfba_pkg::FUNC_ALLOC)
                    begin
                        state_next = ST_SEARCH;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                        if (!in_range)
                        begin
                            res_st_next = nfba_pkg::STAT_RANGE;
                        end
                        else if (any_used)
                        begin
                            res_st_next = nfba_pkg::STAT_DONE;
                        end
                        else
                        begin
                            res_st_next = nfba_pkg::STAT_NOTUSED;
                        end
                    end
                end
            end
            ST_SEARCH:
            begin
                if (any_hit)
                begin
                    res_id_next = hit_id_x[7:0];
                    res_st_next = nfba_pkg::STAT_DONE;
                    ptr_next    = (nxt_id == (GW + 1)'(MAX_IDS)) ? '0 : nxt_id[GW-1:0];
                    state_next  = ST_DONE;
                end
                else if (step_reg == SW'(NCELLS))
                begin
                    res_id_next = '0;
                    res_st_next = nfba_pkg::STAT_FULL;
                    state_next  = ST_DONE;
                end
                else
                begin
                    step_next = step_reg + SW'(1);
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    result_id_next = res_id_reg;
                    status_next    = res_st_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            ptr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            ptr_reg       <= ptr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload registers
    always_ff @(posedge clk)
    begin
        res_id_reg    <= res_id_next;
        res_st_reg    <= res_st_next;
        result_id_reg <= result_id_next;
        status_reg    <= status_next;
    end

    assign out_valid = out_valid_reg;
    assign result_id = result_id_reg;
    assign status    = status_reg;

    // checks
    `NFBA_CHECK_ONEHOT0(a_single_hit, hit_vec)
    `NFBA_CHECK_ONEHOT0(a_single_token, tok_vec)
    `NFBA_CHECK_IMPL(a_no_token_when_ready, in_ready, tok_vec == '0)
    `NFBA_CHECK_IMPL(a_hit_only_in_search, any_hit, state_reg == ST_SEARCH)

endmodule

FILE: design/nfba_cell.sv
// one cell of the used map: 32 id bits and a search token stage
// depends on nfba_pkg
module nfba_cell #(
    parameter int VALID_BITS = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  nfba_pkg::nfba_cmd_t cmd,
    input  logic               sel,
    input  nfba_pkg::nfba_tok_t tok_in,
    output nfba_pkg::nfba_tok_t tok_out,
    output nfba_pkg::nfba_rep_t rep
);

    localparam logic [nfba_pkg::CELL_W:0] LIVE_X =
        ((nfba_pkg::CELL_W + 1)'(1) << VALID_BITS) - (nfba_pkg::CELL_W + 1)'(1);
    localparam logic [nfba_pkg::CELL_W-1:0] LIVE = LIVE_X[nfba_pkg::CELL_W-1:0];

    logic [nfba_pkg::CELL_W-1:0] map_reg;
    logic [nfba_pkg::CELL_W-1:0] map_next;
    nfba_pkg::nfba_tok_t         tok_reg;
    nfba_pkg::nfba_tok_t         tok_next;

    logic [nfba_pkg::CELL_W-1:0] window;
    logic [nfba_pkg::CELL_W-1:0] cand;
    logic [nfba_pkg::CELL_W-1:0] pick;
    logic [nfba_pkg::OFF_W-1:0]  slot;
    logic                        hit;

    // free ids visible to the token, first visit skips ids below the pointer
    always_comb
    begin
        window = tok_reg.first ? ({nfba_pkg::CELL_W{1'b1}} << cmd.off)
                               : {nfba_pkg::CELL_W{1'b1}};
        cand   = ~map_reg & LIVE & window;
        hit    = tok_reg.valid & (|cand);
        pick   = cand & (~cand + nfba_pkg::CELL_W'(1));
    end

    // lowest free slot
    always_comb
    begin
        slot = '0;
        for (int k = nfba_pkg::CELL_W - 1; k >= 0; k--)
        begin
            if (cand[k])
            begin
                slot = nfba_pkg::OFF_W'(k);
            end
        end
    end

    // map update: mark on hit, clear on free
    always_comb
    begin
        map_next = map_reg;
        if (hit)
        begin
            map_next = map_reg | pick;
        end
        else if (cmd.free && sel)
        begin
            map_next = map_reg & ~(nfba_pkg::CELL_W'(1) << cmd.off);
        end
    end

    // token load, kill or shift from the left neighbor
    always_comb
    begin
        if (cmd.start)
        begin
            tok_next.valid = sel;
            tok_next.first = 1'b1;
        end
        else if (cmd.kill)
        begin
            tok_next = '0;
        end
        else
        begin
            tok_next = tok_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_reg <= '0;
            tok_reg <= '0;
        end
        else
        begin
            map_reg <= map_next;
            tok_reg <= tok_next;
        end
    end

    // pass the token on only when this cell found nothing
    assign tok_out.valid = tok_reg.valid & ~hit;
    assign tok_out.first = 1'b0;

    assign rep.tok  = tok_reg.valid;
    assign rep.hit  = hit;
    assign rep.used = map_reg[cmd.off];
    assign rep.slot = slot;

endmodule
